>>> rtl/mersenne_twister_bounded_draw_assert.svh
// Assertion macros for the bounded MT19937 draw block.
// Included by the top level; needs nothing else.
`ifndef MERSENNE_TWISTER_BOUNDED_DRAW_ASSERT_SVH
`define MERSENNE_TWISTER_BOUNDED_DRAW_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mtbd_pkg.sv
// Shared constants, types and word functions of the bounded MT19937 draw block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mtbd_pkg;

   localparam int WORD_W       = 32;
   localparam int TABLE_WORDS  = 624;
   localparam int MIDDLE_OFFSET = 397;
   localparam int FAR_WRAP     = TABLE_WORDS - MIDDLE_OFFSET;
   localparam int ADDR_W       = $clog2(TABLE_WORDS);
   localparam int IDX_W        = 10;
   localparam int STEP_W       = $clog2(WORD_W);

   localparam logic [IDX_W-1:0]  IDX_EXHAUSTED = IDX_W'(TABLE_WORDS);
   localparam logic [IDX_W-1:0]  IDX_UNSEEDED  = IDX_W'(TABLE_WORDS + 1);

   localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
   localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
   localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
   localparam logic [WORD_W-1:0] SEED_MULT    = 32'd69069;
   localparam logic [WORD_W-1:0] SEED_RESET   = 32'd4357;
   localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // table write request
   typedef struct packed {
      logic     en;
      addr_type addr;
      word_type data;
   } ram_wr_type;

   // remainder unit status
   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

   function automatic word_type twist(input word_type cur, input word_type nxt,
                                      input word_type far);
      word_type y;
      word_type r;
      y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
      r = far ^ (y >> 1);
      if (y[0]) begin
         r = r ^ TWIST_MATRIX;
      end
      return r;
   endfunction

   function automatic word_type temper(input word_type w);
      word_type y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

`default_nettype wire

>>> rtl/mtbd_ram.sv
// State table memory: one write port, two registered read ports.
// Depends on mtbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtbd_ram import mtbd_pkg::*; (
   input  logic       clock,
   input  ram_wr_type wr,
   input  addr_type   rd_addr_a,
   input  addr_type   rd_addr_b,
   output word_type   rd_data_a,
   output word_type   rd_data_b
);

   word_type table_mem [TABLE_WORDS];
   word_type rd_data_a_ff;
   word_type rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         table_mem[wr.addr] <= wr.data;
      end
      rd_data_a_ff <= table_mem[rd_addr_a];
      rd_data_b_ff <= table_mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

>>> rtl/mtbd_mod.sv
// Restoring remainder unit, one quotient bit per cycle.
// Depends on mtbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtbd_mod import mtbd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  word_type       dividend,
   input  word_type       divisor,
   output mod_status_type status,
   output word_type       remainder
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

   word_type          rem_ff, rem_in;
   word_type          dvd_ff, dvd_in;
   word_type          dvr_ff, dvr_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   diff;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, dvd_ff[WORD_W-1]};
      fits    = shifted >= {1'b0, dvr_ff};
      diff    = shifted - {1'b0, dvr_ff};

      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvr_in  = dvr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dvr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvr_ff <= dvr_in;
      cnt_ff <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire

>>> rtl/mersenne_twister_bounded_draw.sv
// Top level of the bounded MT19937 draw block: sequencer, table memory, remainder unit.
// Depends on mtbd_pkg, mtbd_ram, mtbd_mod and mersenne_twister_bounded_draw_assert.svh.
//
// Use:
//  - Raise start with req_bound while busy is low; that edge takes the transaction.
//  - The result appears on rsp_value, flagged by rsp_valid for exactly one cycle.
//    The receiver cannot stall; it must take the result in that cycle.
//  - A bound of zero returns 0 in the cycle after the transaction, touching nothing.
//  - A nonzero bound returns the next tempered word modulo the bound: the word is
//    read, tempered and passed through the 32-step remainder unit. busy drops in
//    the cycle of the result, so a new transaction can be taken at the edge
//    that ends it.
//  - The draw that finds the table used up first regenerates it: one read-ahead
//    of word 0, then a read/write pair per word on the table memory.
//  - After reset or a csr_wr_en write of the seed, the next nonzero-bound draw
//    also refills the table from the seed, one word per cycle.
//  - Reset loads seed 4357 and marks the table unseeded; the table itself is
//    not cleared. Write the seed only while busy is low and no result is due.
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_bounded_draw import mtbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_bound,
   // result channel
   output logic        rsp_valid,
   output logic [31:0] rsp_value,
   // seed register
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_FILL     = 3'd1;  // seed fill, one word per cycle
   localparam logic [2:0] S_PRELOAD  = 3'd2;  // fetch word 0 for the twist
   localparam logic [2:0] S_REGEN_RD = 3'd3;  // read next and far words of k
   localparam logic [2:0] S_REGEN_WR = 3'd4;  // write new word k
   localparam logic [2:0] S_DRAW_RD  = 3'd5;  // read word at the read index
   localparam logic [2:0] S_TEMPER   = 3'd6;  // temper, launch remainder
   localparam logic [2:0] S_DIVIDE   = 3'd7;  // wait on the remainder unit

   localparam addr_type LAST_ADDR = ADDR_W'(TABLE_WORDS - 1);

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;         // read index, unseeded/exhausted codes
   word_type         seed_ff, seed_in;
   word_type         bound_ff, bound_in;
   addr_type         k_ff, k_in;             // fill / regeneration position
   word_type         fill_word_ff, fill_word_in;
   word_type         cur_ff, cur_in;         // old word k for the twist
   logic             rsp_valid_ff, rsp_valid_in;
   word_type         rsp_value_ff, rsp_value_in;

   ram_wr_type       ram_wr;
   addr_type         rd_addr_a, rd_addr_b;
   word_type         rd_data_a, rd_data_b;

   logic             mod_start;
   word_type         mod_dividend;
   mod_status_type   mod_status;
   word_type         mod_remainder;

   logic             accept;
   addr_type         next_addr;
   addr_type         far_addr;

   assign accept = start && (state_ff == S_IDLE);

   // Neighbors of word k. Past the wrap point the far word has already been
   // rewritten in this pass, which the in-place update calls for.
   assign next_addr = (k_ff == LAST_ADDR) ? '0 : k_ff + ADDR_W'(1);
   assign far_addr  = (k_ff < ADDR_W'(FAR_WRAP)) ? k_ff + ADDR_W'(MIDDLE_OFFSET)
                                                 : k_ff - ADDR_W'(FAR_WRAP);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      seed_in      = seed_ff;
      bound_in     = bound_ff;
      k_in         = k_ff;
      fill_word_in = fill_word_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;

      ram_wr       = '0;
      rd_addr_a    = '0;
      rd_addr_b    = '0;
      mod_start    = 1'b0;
      mod_dividend = temper(rd_data_a);

      unique case (state_ff)
         S_IDLE: begin
            if (csr_wr_en) begin
               seed_in = csr_wr_data;
               idx_in  = IDX_UNSEEDED;
            end
            if (accept) begin
               bound_in = req_bound;
               if (req_bound == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
               end else if (idx_ff == IDX_UNSEEDED) begin
                  k_in         = '0;
                  fill_word_in = seed_ff;
                  state_in     = S_FILL;
               end else if (idx_ff == IDX_EXHAUSTED) begin
                  state_in = S_PRELOAD;
               end else begin
                  state_in = S_DRAW_RD;
               end
            end
         end
         S_FILL: begin
            ram_wr.en    = 1'b1;
            ram_wr.addr  = k_ff;
            ram_wr.data  = fill_word_ff;
            fill_word_in = fill_word_ff * SEED_MULT;
            k_in         = k_ff + ADDR_W'(1);
            if (k_ff == LAST_ADDR) begin
               state_in = S_PRELOAD;
            end
         end
         S_PRELOAD: begin
            rd_addr_a = '0;
            k_in      = '0;
            state_in  = S_REGEN_RD;
         end
         S_REGEN_RD: begin
            // word 0 fetched by the preload is on the read port now
            if (k_ff == '0) begin
               cur_in = rd_data_a;
            end
            rd_addr_a = next_addr;
            rd_addr_b = far_addr;
            state_in  = S_REGEN_WR;
         end
         S_REGEN_WR: begin
            // read and write of a step never share a cycle, so no forwarding
            ram_wr.en   = 1'b1;
            ram_wr.addr = k_ff;
            ram_wr.data = twist(cur_ff, rd_data_a, rd_data_b);
            cur_in      = rd_data_a;
            if (k_ff == LAST_ADDR) begin
               idx_in   = '0;
               state_in = S_DRAW_RD;
            end else begin
               k_in     = k_ff + ADDR_W'(1);
               state_in = S_REGEN_RD;
            end
         end
         S_DRAW_RD: begin
            rd_addr_a = idx_ff[ADDR_W-1:0];
            state_in  = S_TEMPER;
         end
         S_TEMPER: begin
            mod_start = 1'b1;
            idx_in    = idx_ff + IDX_W'(1);
            state_in  = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (mod_status.done) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = mod_remainder;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= IDX_UNSEEDED;
         seed_ff      <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bound_ff     <= bound_in;
      k_ff         <= k_in;
      fill_word_ff <= fill_word_in;
      cur_ff       <= cur_in;
      rsp_value_ff <= rsp_value_in;
   end

   mtbd_ram u_ram (
      .clock     (clock),
      .wr        (ram_wr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mtbd_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (bound_ff),
      .status    (mod_status),
      .remainder (mod_remainder)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // ---------------------------------------------------------------- checks
`include "mersenne_twister_bounded_draw_assert.svh"

   `MTBD_ASSERT_NEXT(a_zero_bound, clock, reset, accept && (req_bound == '0), rsp_valid && (rsp_value == '0) && !busy, "zero bound must answer 0 at once")
   `MTBD_ASSERT_NOW(a_draw_in_range, clock, reset, state_ff == S_DRAW_RD, idx_ff < IDX_EXHAUSTED, "draw read past the table")
   `MTBD_ASSERT_NOW(a_result_idle, clock, reset, rsp_valid, !busy && !mod_status.busy, "result shown while work is pending")
   `MTBD_ASSERT_NOW(a_mod_owned, clock, reset, mod_status.busy || mod_status.done, state_ff == S_DIVIDE, "remainder unit active outside the divide step")

endmodule

`default_nettype wire

>>> tb/mtbd_draw_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the bounded MT19937 draw block. It mirrors the generator
// state, predicts each draw and compares it with the result port. No imports.

module mtbd_draw_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_bound,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_value,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int unsigned mismatch_count,
   output int unsigned draws_pending
);

   localparam int          TABLE_WORDS   = 624;
   localparam int          MIDDLE_OFFSET = 397;
   localparam int          MAX_REPORTS   = 10;
   localparam logic [9:0]  PTR_EXHAUSTED = 10'd624;
   localparam logic [9:0]  PTR_UNSEEDED  = 10'd625;
   localparam logic [31:0] SEED_DEFAULT  = 32'd4357;
   localparam logic [31:0] SEED_MULT     = 32'd69069;
   localparam logic [31:0] TWIST_XOR     = 32'h9908_b0df;
   localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_MASK_C = 32'hefc6_0000;

   typedef struct {
      logic [31:0] bound;
      logic [31:0] value;
   } pending_draw_t;

   pending_draw_t expected_draws[$];
   pending_draw_t oldest;
   logic [31:0]   mt_words [TABLE_WORDS];
   logic [9:0]    word_ptr;
   logic [31:0]   seed_reg;
   int unsigned   errors = 0;

   function automatic logic [31:0] temper_word(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TEMPER_MASK_B);
      y = y ^ ((y << 15) & TEMPER_MASK_C);
      return y ^ (y >> 18);
   endfunction

   function automatic logic [31:0] twisted(input logic [31:0] cur, input logic [31:0] nxt,
                                           input logic [31:0] far);
      logic [31:0] y;
      y = {cur[31], nxt[30:0]};
      return far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'h0);
   endfunction

   function void seed_table();
      int k;
      mt_words[0] = seed_reg;
      for (k = 1; k < TABLE_WORDS; k++)
         mt_words[k] = mt_words[k-1] * SEED_MULT;
   endfunction

   // in place, low index first: the wrapped taps see already updated words
   function void regenerate_table();
      int k;
      for (k = 0; k < TABLE_WORDS; k++)
         mt_words[k] = twisted(mt_words[k], mt_words[(k + 1) % TABLE_WORDS],
                               mt_words[(k + MIDDLE_OFFSET) % TABLE_WORDS]);
      word_ptr = 10'd0;
   endfunction

   function logic [31:0] predict_draw(input logic [31:0] bound);
      logic [31:0] y;
      // zero bound leaves the generator alone
      if (bound == 32'd0)
         return 32'd0;
      if (word_ptr >= PTR_EXHAUSTED) begin
         if (word_ptr != PTR_EXHAUSTED)
            seed_table();
         regenerate_table();
      end
      y = temper_word(mt_words[word_ptr]);
      word_ptr = word_ptr + 10'd1;
      return y % bound;
   endfunction

   function void flag_error(input string msg);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("[%0t] %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         seed_reg = SEED_DEFAULT;
         word_ptr = PTR_UNSEEDED;
         expected_draws.delete();
      end else begin
         if (csr_wr_en) begin
            seed_reg = csr_wr_data;
            word_ptr = PTR_UNSEEDED;
         end
         // retire before accepting: a result never belongs to this edge's transaction
         if (rsp_valid) begin
            if (expected_draws.size() == 0) begin
               flag_error($sformatf("unexpected result value 0x%08h", rsp_value));
            end else begin
               oldest = expected_draws.pop_front();
               if (rsp_value !== oldest.value)
                  flag_error($sformatf("bound 0x%08h: value expected 0x%08h actual 0x%08h",
                                       oldest.bound, oldest.value, rsp_value));
            end
         end
         if (start && !busy)
            expected_draws.push_back('{bound: req_bound, value: predict_draw(req_bound)});
      end
      mismatch_count <= errors;
      draws_pending  <= expected_draws.size();
   end

endmodule

>>> tb/tb_mersenne_twister_bounded_draw.sv
`timescale 1ns / 1ps
// Testbench top for the bounded MT19937 draw block: clock, reset, stimulus, verdict.
// Depends on mersenne_twister_bounded_draw (RTL) and mtbd_draw_checker.

module tb_mersenne_twister_bounded_draw;

   localparam int TAIL_CYCLES = 40;     // idle tail after the final drain

   logic        clock;
   logic        reset       = 1'b1;
   logic        start       = 1'b0;
   logic [31:0] req_bound   = 32'd0;
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = 32'd0;
   logic        busy;
   logic        rsp_valid;
   logic [31:0] rsp_value;

   int unsigned mismatch_count;
   int unsigned draws_pending;

   mersenne_twister_bounded_draw i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_bound  (req_bound),
      .rsp_valid  (rsp_valid),
      .rsp_value  (rsp_value),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // prediction and compare live in the checker; this module only drives
   mtbd_draw_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_bound     (req_bound),
      .rsp_valid     (rsp_valid),
      .rsp_value     (rsp_value),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatch_count(mismatch_count),
      .draws_pending (draws_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog. The timeout lies well above the slowest legal run: ~1250 draws,
   // each with its longest idle gap, a regeneration per 624 draws and a refill
   // per seed phase.
   initial begin
      #6_000_000;
      $display("tb_mersenne_twister_bounded_draw failed");
      $finish;
   end

   // Idle burst after a transaction: mostly none, so back-to-back stretches
   // occur, otherwise a random nonzero gap. Quiet phases never idle.
   function automatic int idle_burst(input bit quiet);
      if (quiet || $urandom_range(0, 2) != 0)
         return 0;
      return $urandom_range(1, 12);
   endfunction

   // Bound mix: zero, tiny bounds, powers of two, all-ones masks and full
   // 32-bit random values, which toggle every bit.
   function automatic logic [31:0] pick_bound();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1, 2:    return $urandom_range(1, 16);
         3:       return 32'd1 << $urandom_range(0, 31);
         4:       return 32'hffff_ffff >> $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   // One transaction. Called at a rising edge; returns at the edge that
   // accepted it (start high, busy low), start still high unless a gap followed.
   task automatic issue(input logic [31:0] bound, input int gap);
      start     <= 1'b1;
      req_bound <= bound;
      do
         @(posedge clock);
      while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every predicted draw has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (draws_pending != 0)
         @(posedge clock);
   endtask

   // Seed writes happen only with the block idle. A second value, when given,
   // lands on the very next edge and is the one that sticks.
   task automatic program_seed(input logic [31:0] seed, input bit twice,
                               input logic [31:0] seed2);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= seed;
      @(posedge clock);
      if (twice) begin
         csr_wr_data <= seed2;
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Random draws; now and then the sender holds off until the block is empty.
   task automatic random_draws(input int count, input bit quiet);
      int n;
      for (n = 0; n < count; n++) begin
         if (!quiet && $urandom_range(0, 39) == 0)
            drain();
         issue(pick_bound(), idle_burst(quiet));
      end
   endtask

   // Short directed set run right after a seed change: a zero bound first,
   // which must neither seed nor advance, then the bound extremes.
   task automatic seed_phase_opening();
      issue(32'd0, 0);
      issue(32'd1, idle_burst(1'b0));
      issue(32'hffff_ffff, 0);
      issue(32'd0, 0);
      issue(32'h8000_0000, idle_burst(1'b0));
   endtask

   initial begin
      // synchronous reset, asserted from time zero, once only
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset seed. Zero bound while unseeded, then extremes and
      // alternating bit patterns.
      issue(32'd0, 0);
      issue(32'd1, 0);
      issue(32'hffff_ffff, 0);
      issue(32'h8000_0000, 3);
      issue(32'h7fff_ffff, 0);
      issue(32'd2, 0);
      issue(32'd3, 1);
      issue(32'd0, 0);
      issue(32'h0000_ffff, 0);
      issue(32'hffff_0000, 12);
      issue(32'd10, 0);
      issue(32'haaaa_aaaa, 0);
      issue(32'h5555_5555, 0);

      // Long run on the reset seed: crosses the 624-word table end, so the
      // mid-stream regeneration is exercised.
      random_draws(700, 1'b0);

      // Seed extremes
      program_seed(32'h0000_0000, 1'b0, 32'h0);
      seed_phase_opening();
      random_draws(20, 1'b0);

      program_seed(32'hffff_ffff, 1'b0, 32'h0);
      seed_phase_opening();
      random_draws(20, 1'b0);

      // Random seeds; one phase takes two back-to-back writes, one rewrites
      // the reset value mid-table.
      program_seed($urandom(), 1'b1, $urandom());
      random_draws(110, 1'b0);

      program_seed(32'd4357, 1'b0, 32'h0);
      random_draws(110, 1'b0);

      program_seed($urandom(), 1'b0, 32'h0);
      random_draws(110, 1'b0);

      // final stretch without any idling
      program_seed($urandom(), 1'b0, 32'h0);
      random_draws(110, 1'b1);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && draws_pending == 0)
         $display("tb_mersenne_twister_bounded_draw passed");
      else
         $display("tb_mersenne_twister_bounded_draw failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/mtbd_pkg.sv
rtl/mtbd_ram.sv
rtl/mtbd_mod.sv
rtl/mersenne_twister_bounded_draw.sv
tb/mtbd_draw_checker.sv
tb/tb_mersenne_twister_bounded_draw.sv
